// ----- hw/rtl/rotating_file_sequence_ring_macros.svh -----
// assertion macros used by the checker file of the rotating file sequence ring
`ifndef ROTATING_FILE_SEQUENCE_RING_MACROS_SVH
`define ROTATING_FILE_SEQUENCE_RING_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define RFSR_ASSERT_CLK(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// concurrent assertion on the default clk and rst_n of the enclosing module
`define RFSR_ASSERT(lbl, prop, msg) \
  `RFSR_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

// ----- hw/rtl/rfsr_pkg.sv -----
// shared types, widths and codes of the rotating file sequence ring
package rfsr_pkg;

  localparam int FUNC_W        = 3;
  localparam int SEQ_W         = 64;
  localparam int IDX_W         = 4;
  localparam int CNT_W         = 5;
  localparam int PTR_OUT_W     = 4;
  localparam int DEF_MAX_FILES = 16;

  localparam logic [SEQ_W-1:0] SEQ_NONE = {SEQ_W{1'b1}};

  // operation selector codes
  localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ROT_READ  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_ROT_WRITE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_COMMIT    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_QUERY     = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_EXEC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic mod_start;
    logic rd_issue;
    logic rd_use_mod;
    logic exec;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_mod;
    logic mod_done;
  } dp_stat_t;

endpackage

// ----- hw/rtl/rotating_file_sequence_ring.sv -----
// top level of the rotating file sequence ring
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall    in_func, in_seq, in_file_index
//   out_     output     out_valid / out_stall  in_file, index_error, seq head/tail, read/tail file
//   cfg_     input      cfg_valid / cfg_ready  cfg_data (file count)
//
// an item runs transfer and slot read, then execute and result load
// a rotate write whose write head sits at or past a lowered file count first waits on
//   the bit-serial remainder unit (MOD_W = 6 at 16 files), then reads its slots
// synchronous active-low reset; every slot reads as empty through its valid bit
// a new item is taken while the previous result waits under out_stall
// a stalled result holds the execute step until the result register frees
module rotating_file_sequence_ring #(
  parameter int MAX_FILES = rfsr_pkg::DEF_MAX_FILES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rfsr_pkg::CNT_W-1:0]     cfg_data,
  // input items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rfsr_pkg::FUNC_W-1:0]    in_func,
  input  logic [rfsr_pkg::SEQ_W-1:0]     in_seq,
  input  logic [rfsr_pkg::IDX_W-1:0]     in_file_index,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_in_file,
  output logic                           out_index_error,
  output logic [rfsr_pkg::SEQ_W-1:0]     out_seq_head_out,
  output logic [rfsr_pkg::SEQ_W-1:0]     out_seq_tail_out,
  output logic [rfsr_pkg::PTR_OUT_W-1:0] out_read_file_out,
  output logic [rfsr_pkg::PTR_OUT_W-1:0] out_tail_file_out
);
  import rfsr_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // user changes file count only between items (unenforced); port always open
  assign cfg_ready = 1'b1;

  // sequencer: owns the input and output handshakes and the result valid flag
  rfsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // ring state, slot memories and result payload
  rfsr_dpath #(
    .MAX_FILES (MAX_FILES)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .in_func           (in_func),
    .in_seq            (in_seq),
    .in_file_index     (in_file_index),
    .out_in_file       (out_in_file),
    .out_index_error   (out_index_error),
    .out_seq_head_out  (out_seq_head_out),
    .out_seq_tail_out  (out_seq_tail_out),
    .out_read_file_out (out_read_file_out),
    .out_tail_file_out (out_tail_file_out)
  );

endmodule

// ----- hw/rtl/rfsr_mod.sv -----
// restoring remainder unit, one quotient bit per cycle
module rfsr_mod #(
  parameter int W = 6
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r;
  logic [W-1:0]  r_r;
  logic [CW-1:0] n_r;
  logic          act_r;
  logic [W-1:0]  trial;
  logic [W-1:0]  r_step;

  // remainder stays below the divisor, so its top bit is free
  assign trial  = {r_r[W-2:0], q_r[W-1]};
  assign r_step = (trial >= divisor) ? (trial - divisor) : trial;
  assign done   = act_r && (n_r == '0);
  assign rem    = r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      n_r   <= '0;
    end else if (start) begin
      act_r <= 1'b1;
      n_r   <= CW'(W);
    end else if (act_r) begin
      if (n_r != '0) begin
        n_r <= n_r - CW'(1);
      end else begin
        act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
    end else if (act_r && (n_r != '0)) begin
      q_r <= {q_r[W-2:0], 1'b0};
      r_r <= r_step;
    end
  end

endmodule

// ----- hw/rtl/rfsr_dpath.sv -----
// datapath: pointers, overall sequence range, slot memories and result register
module rfsr_dpath #(
  parameter int MAX_FILES = rfsr_pkg::DEF_MAX_FILES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rfsr_pkg::ctrl_cmd_t            cmd,
  output rfsr_pkg::dp_stat_t             stat,
  input  logic                           cfg_we,
  input  logic [rfsr_pkg::CNT_W-1:0]     cfg_data,
  input  logic [rfsr_pkg::FUNC_W-1:0]    in_func,
  input  logic [rfsr_pkg::SEQ_W-1:0]     in_seq,
  input  logic [rfsr_pkg::IDX_W-1:0]     in_file_index,
  output logic                           out_in_file,
  output logic                           out_index_error,
  output logic [rfsr_pkg::SEQ_W-1:0]     out_seq_head_out,
  output logic [rfsr_pkg::SEQ_W-1:0]     out_seq_tail_out,
  output logic [rfsr_pkg::PTR_OUT_W-1:0] out_read_file_out,
  output logic [rfsr_pkg::PTR_OUT_W-1:0] out_tail_file_out
);
  import rfsr_pkg::*;

  localparam int PTR_W = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int MOD_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

  logic [CNT_W-1:0]     fcount_r;
  logic [MOD_W-1:0]     cnt;
  logic                 cnt_nz;

  logic [PTR_W-1:0]     rp_r, rp_nxt;
  logic [PTR_W-1:0]     wp_r, wp_nxt;
  logic [PTR_W-1:0]     tp_r, tp_nxt;
  logic [SEQ_W-1:0]     head_r, head_nxt;
  logic [SEQ_W-1:0]     tail_r, tail_nxt;
  logic [MAX_FILES-1:0] valid_r, valid_nxt;

  logic [SEQ_W-1:0]     first_mem [MAX_FILES];
  logic [SEQ_W-1:0]     last_mem  [MAX_FILES];

  logic [FUNC_W-1:0]    func_r;
  logic [SEQ_W-1:0]     seq_r;
  logic [IDX_W-1:0]     idx_r;
  logic [PTR_W-1:0]     w_new_r, t_new_r;
  logic [SEQ_W-1:0]     first_rd_r, last_rd_r;
  logic                 fv_r, lv_r;

  logic [MOD_W-1:0]     wp_inc, w_cand_inc, mod_rem;
  logic                 mod_done;
  logic [PTR_W-1:0]     w_fast, w_cand, t_cand, idx_slot, fa, la;
  logic [FUNC_W-1:0]    rd_func;
  logic [SEQ_W-1:0]     first_q, last_q, first_wr;
  logic                 mem_we, in_file_c, err_c;

  // result register
  logic                 in_file_r, err_r;
  logic [SEQ_W-1:0]     ohead_r, otail_r;
  logic [PTR_OUT_W-1:0] orp_r, otp_r;

  assign cnt    = (MOD_W'(fcount_r) > MOD_W'(MAX_FILES)) ? MOD_W'(MAX_FILES)
                                                         : MOD_W'(fcount_r);
  assign cnt_nz = (cnt != '0);

  // write head advance when it already sits below the count
  assign wp_inc = MOD_W'(wp_r) + MOD_W'(1);
  assign w_fast = (wp_inc == cnt) ? '0 : PTR_W'(wp_inc);

  assign stat = '{need_mod: (in_func == FN_ROT_WRITE) && cnt_nz && (MOD_W'(wp_r) >= cnt),
                  mod_done: mod_done};

  rfsr_mod #(
    .W (MOD_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (wp_inc),
    .divisor  (cnt),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // read addresses for the slots that the operation looks at
  always_comb begin
    w_cand     = cmd.rd_use_mod ? PTR_W'(mod_rem) : w_fast;
    w_cand_inc = MOD_W'(w_cand) + MOD_W'(1);
    // tail pushed only when the new write slot lands on it
    if (tp_r == w_cand) begin
      t_cand = (w_cand_inc == cnt) ? '0 : PTR_W'(w_cand_inc);
    end else begin
      t_cand = tp_r;
    end
    idx_slot = (MOD_W'(in_file_index) < MOD_W'(MAX_FILES)) ? PTR_W'(in_file_index) : '0;
    rd_func  = cmd.rd_use_mod ? FN_ROT_WRITE : in_func;
    case (rd_func)
      FN_ROT_WRITE: begin
        fa = cnt_nz ? t_cand : wp_r;
        la = cnt_nz ? w_cand : wp_r;
      end
      FN_COMMIT: begin
        fa = wp_r;
        la = wp_r;
      end
      default: begin
        fa = idx_slot;
        la = idx_slot;
      end
    endcase
  end

  // operation execution
  always_comb begin
    first_q   = fv_r ? first_rd_r : SEQ_NONE;
    last_q    = lv_r ? last_rd_r : SEQ_NONE;
    first_wr  = (first_q == SEQ_NONE) ? seq_r : first_q;
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    tp_nxt    = tp_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    valid_nxt = valid_r;
    mem_we    = 1'b0;
    in_file_c = 1'b0;
    err_c     = 1'b0;
    if (cmd.exec) begin
      case (func_r)
        FN_CLEAR: begin
          rp_nxt    = '0;
          wp_nxt    = '0;
          tp_nxt    = '0;
          head_nxt  = SEQ_NONE;
          tail_nxt  = SEQ_NONE;
          valid_nxt = '0;
        end
        FN_ROT_READ: begin
          if (cnt_nz) begin
            rp_nxt = wp_r;
          end
        end
        FN_ROT_WRITE: begin
          if (cnt_nz) begin
            wp_nxt = w_new_r;
            tp_nxt = t_new_r;
            if (last_q != SEQ_NONE) begin
              tail_nxt = first_q;
            end
            valid_nxt[w_new_r] = 1'b0;
          end
        end
        FN_COMMIT: begin
          head_nxt = seq_r;
          if (tail_r == SEQ_NONE) begin
            tail_nxt = seq_r;
          end
          if (cnt_nz) begin
            mem_we          = 1'b1;
            valid_nxt[wp_r] = 1'b1;
          end
        end
        FN_QUERY: begin
          if (!cnt_nz) begin
            in_file_c = 1'b1;
          end else if (MOD_W'(idx_r) >= cnt) begin
            err_c = 1'b1;
          end else if (seq_r != SEQ_NONE) begin
            in_file_c = (seq_r >= first_q) && (seq_r <= last_q);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcount_r <= '0;
      rp_r     <= '0;
      wp_r     <= '0;
      tp_r     <= '0;
      head_r   <= SEQ_NONE;
      tail_r   <= SEQ_NONE;
      valid_r  <= '0;
    end else begin
      if (cfg_we) begin
        fcount_r <= cfg_data;
      end
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      tp_r    <= tp_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_func;
      seq_r  <= in_seq;
      idx_r  <= in_file_index;
    end
    if (cmd.rd_issue) begin
      w_new_r <= w_cand;
      t_new_r <= t_cand;
      fv_r    <= valid_r[fa];
      lv_r    <= valid_r[la];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      first_mem[wp_r] <= first_wr;
    end
    if (cmd.rd_issue) begin
      first_rd_r <= first_mem[fa];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      last_mem[wp_r] <= seq_r;
    end
    if (cmd.rd_issue) begin
      last_rd_r <= last_mem[la];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      in_file_r <= in_file_c;
      err_r     <= err_c;
      ohead_r   <= head_nxt;
      otail_r   <= tail_nxt;
      orp_r     <= PTR_OUT_W'(rp_nxt);
      otp_r     <= PTR_OUT_W'(tp_nxt);
    end
  end

  assign out_in_file       = in_file_r;
  assign out_index_error   = err_r;
  assign out_seq_head_out  = ohead_r;
  assign out_seq_tail_out  = otail_r;
  assign out_read_file_out = orp_r;
  assign out_tail_file_out = otp_r;

endmodule

// ----- hw/rtl/rfsr_ctrl.sv -----
// controller: sequences accept, slot read, remainder wait and execute
module rfsr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  rfsr_pkg::dp_stat_t  stat,
  output rfsr_pkg::ctrl_cmd_t cmd
);
  import rfsr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   exec_ok;

  assign exec_ok = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.need_mod ? ST_MOD : ST_EXEC;
        end
      end
      ST_MOD: begin
        if (stat.mod_done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall       = (state_r != ST_IDLE);
    cmd.accept     = (state_r == ST_IDLE) && in_valid;
    cmd.mod_start  = cmd.accept && stat.need_mod;
    cmd.rd_issue   = (cmd.accept && !stat.need_mod) || (state_r == ST_READ);
    cmd.rd_use_mod = (state_r == ST_READ);
    cmd.exec       = exec_ok;
    if (exec_ok) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/rfsr_checker.sv -----
// port-level assertions for the rotating file sequence ring, bound to the top level
`include "rotating_file_sequence_ring_macros.svh"

module rfsr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_in_file,
  input logic                       out_index_error,
  input logic [rfsr_pkg::SEQ_W-1:0] out_seq_head_out,
  input logic [rfsr_pkg::SEQ_W-1:0] out_seq_tail_out
);

  `RFSR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_seq_head_out) && $stable(out_seq_tail_out), "stalled result changed")
  `RFSR_ASSERT(a_busy_after_transfer, in_valid && !in_stall |=> in_stall, "block not busy after input transfer")
  `RFSR_ASSERT(a_err_no_hit, out_valid && out_index_error |-> !out_in_file, "index error with in_file set")
  `RFSR_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(in_stall), "result appeared without work in progress")

endmodule

bind rotating_file_sequence_ring rfsr_checker u_rfsr_checker (.*);

// ----- tb/rotating_file_sequence_ring_tb.sv -----
// self-checking testbench of the rotating file sequence ring: directed cases, then random traffic
module rotating_file_sequence_ring_tb;
  import rfsr_pkg::*;

  localparam int NFILES        = DEF_MAX_FILES;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_MAX    = 10;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_OPS     = 96;
  localparam int SETTLE_CYCLES = 16;

  typedef logic [SEQ_W-1:0] seq_t;

  // one result transfer, field for field as the block reports it
  typedef struct packed {
    logic                 in_file;
    logic                 index_error;
    seq_t                 head;
    seq_t                 tail;
    logic [PTR_OUT_W-1:0] read_file;
    logic [PTR_OUT_W-1:0] tail_file;
  } ring_status_t;

  // mirror of the file ring plus the queue of statuses still owed by the block
  class ring_tracker;
    seq_t         first_seq [NFILES];
    seq_t         last_seq  [NFILES];
    seq_t         head_seq;
    seq_t         tail_seq;
    int           rd_ptr;
    int           wr_ptr;
    int           tl_ptr;
    int           file_count;
    ring_status_t due_status [$];
    int           errors;
    int           results;
    int           hits;
    int           index_errors;
    int           op_seen [8];

    function new();
      file_count   = 0;
      errors       = 0;
      results      = 0;
      hits         = 0;
      index_errors = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      clear_ring();
    endfunction

    function void clear_ring();
      foreach (first_seq[i]) begin
        first_seq[i] = SEQ_NONE;
        last_seq[i]  = SEQ_NONE;
      end
      head_seq = SEQ_NONE;
      tail_seq = SEQ_NONE;
      rd_ptr   = 0;
      wr_ptr   = 0;
      tl_ptr   = 0;
    endfunction

    function int active_files();
      return (file_count > NFILES) ? NFILES : file_count;
    endfunction

    function void set_count(logic [CNT_W-1:0] value);
      file_count = int'(value);
    endfunction

    // applies one accepted operation and queues the status it must report
    function void take_op(logic [FUNC_W-1:0] fn, seq_t s, logic [IDX_W-1:0] ix);
      ring_status_t st;
      int           cnt;
      cnt = active_files();
      st  = '0;
      op_seen[fn]++;
      case (fn)
        FN_CLEAR: clear_ring();
        FN_ROT_READ: begin
          if (cnt != 0) rd_ptr = wr_ptr;
        end
        FN_ROT_WRITE: begin
          if (cnt != 0) begin
            wr_ptr = (wr_ptr + 1) % cnt;
            if (wr_ptr == tl_ptr) tl_ptr = (tl_ptr + 1) % cnt;
            if (last_seq[wr_ptr] != SEQ_NONE) tail_seq = first_seq[tl_ptr];
            last_seq[wr_ptr]  = SEQ_NONE;
            first_seq[wr_ptr] = SEQ_NONE;
          end
        end
        FN_COMMIT: begin
          head_seq = s;
          if (tail_seq == SEQ_NONE) tail_seq = s;
          if (cnt != 0) begin
            last_seq[wr_ptr] = s;
            if (first_seq[wr_ptr] == SEQ_NONE) first_seq[wr_ptr] = s;
          end
        end
        FN_QUERY: begin
          if (cnt == 0) st.in_file = 1'b1;
          else if (int'(ix) >= cnt) st.index_error = 1'b1;
          else if (s != SEQ_NONE) st.in_file = (s >= first_seq[ix]) && (s <= last_seq[ix]);
          if (st.in_file) hits++;
          if (st.index_error) index_errors++;
        end
        default: ;
      endcase
      st.head      = head_seq;
      st.tail      = tail_seq;
      st.read_file = PTR_OUT_W'(rd_ptr);
      st.tail_file = PTR_OUT_W'(tl_ptr);
      due_status.push_back(st);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= REPORT_MAX) $display("%s", msg);
    endfunction

    function void match_status(ring_status_t got);
      ring_status_t want;
      string        bad;
      results++;
      if (due_status.size() == 0) begin
        note_error($sformatf("unexpected result: head=%h tail=%h read=%0d tail file=%0d",
                             got.head, got.tail, got.read_file, got.tail_file));
        return;
      end
      want = due_status.pop_front();
      bad  = "";
      if (got.in_file !== want.in_file) bad = {bad, " in_file"};
      if (got.index_error !== want.index_error) bad = {bad, " index_error"};
      if (got.head !== want.head) bad = {bad, " newest_seq"};
      if (got.tail !== want.tail) bad = {bad, " oldest_seq"};
      if (got.read_file !== want.read_file) bad = {bad, " read_file"};
      if (got.tail_file !== want.tail_file) bad = {bad, " tail_file"};
      if (bad != "")
        note_error($sformatf({"result %0d mismatch in%s\n",
                              "  expected in_file=%0b err=%0b head=%h tail=%h read=%0d tfile=%0d\n",
                              "  actual   in_file=%0b err=%0b head=%h tail=%h read=%0d tfile=%0d"},
                             results, bad,
                             want.in_file, want.index_error, want.head, want.tail,
                             want.read_file, want.tail_file,
                             got.in_file, got.index_error, got.head, got.tail,
                             got.read_file, got.tail_file));
    endfunction

    function void flush_leftover();
      ring_status_t want;
      while (due_status.size() != 0) begin
        want = due_status.pop_front();
        note_error($sformatf("result never delivered: head=%h tail=%h", want.head, want.tail));
      end
    endfunction
  endclass

  // block ports, all inputs known from time zero
  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CNT_W-1:0]     cfg_data      = '0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic [FUNC_W-1:0]    in_func       = '0;
  seq_t                 in_seq        = '0;
  logic [IDX_W-1:0]     in_file_index = '0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic                 out_in_file;
  logic                 out_index_error;
  seq_t                 out_seq_head_out;
  seq_t                 out_seq_tail_out;
  logic [PTR_OUT_W-1:0] out_read_file_out;
  logic [PTR_OUT_W-1:0] out_tail_file_out;

  ring_tracker book;

  // idling knobs, percent per cycle
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  // long receiver hold-off: the stimulus bumps hold_req, the receiver does the counting
  int          hold_req       = 0;
  int          hold_seen      = 0;
  int          hold_left      = 0;
  int          items_sent     = 0;
  int          settings_used  = 0;
  int unsigned cycle_count    = 0;
  seq_t        seq_cursor;

  rotating_file_sequence_ring u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_seq            (in_seq),
    .in_file_index     (in_file_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_in_file       (out_in_file),
    .out_index_error   (out_index_error),
    .out_seq_head_out  (out_seq_head_out),
    .out_seq_tail_out  (out_seq_tail_out),
    .out_read_file_out (out_read_file_out),
    .out_tail_file_out (out_tail_file_out)
  );

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cycle limit hit with %0d results outstanding", book.due_status.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: check each result transfer, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      book.match_status(ring_status_t'({out_in_file, out_index_error, out_seq_head_out,
                                        out_seq_tail_out, out_read_file_out,
                                        out_tail_file_out}));
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // none, sender only, receiver only, both at a lighter rate
  function void set_idling(int mode);
    case (mode)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 63;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 63;
      end
      default: begin
        send_idle_pct  = 31;
        recv_stall_pct = 31;
      end
    endcase
  endfunction

  // one input transfer; valid drops when a gap is taken or on drain, never between back-to-back items
  task automatic send_op(input logic [FUNC_W-1:0] fn, input seq_t s,
                         input logic [IDX_W-1:0] ix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= fn;
    in_seq        <= s;
    in_file_index <= ix;
    do @(posedge clk); while (in_stall);
    book.take_op(fn, s, ix);
    items_sent++;
  endtask

  // stop offering and wait until every owed result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (book.due_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    book.set_count(value);
    settings_used++;
  endtask

  // mostly commit / rotate / query traffic around live file ranges, a little noise
  task automatic pick_op(output logic [FUNC_W-1:0] fn, output seq_t s,
                         output logic [IDX_W-1:0] ix);
    int   roll;
    int   cnt;
    seq_t lo;
    seq_t hi;
    roll = $urandom_range(99);
    cnt  = book.active_files();
    fn   = FN_QUERY;
    s    = {$urandom, $urandom};
    ix   = IDX_W'($urandom_range(15));
    if (roll < 4) begin
      // raw noise, unused selectors included
      fn = FUNC_W'($urandom_range(7));
    end else if (roll < 6) begin
      fn = FN_CLEAR;
    end else if (roll < 40) begin
      fn         = FN_COMMIT;
      seq_cursor = seq_cursor + seq_t'($urandom_range(1, 9));
      s          = seq_cursor;
    end else if (roll < 56) begin
      fn = FN_ROT_WRITE;
    end else if (roll < 63) begin
      fn = FN_ROT_READ;
    end else begin
      // queries aim mostly at slots in use and at the edges of their ranges
      if (cnt != 0 && $urandom_range(9) < 8) ix = IDX_W'($urandom_range(cnt - 1));
      lo = book.first_seq[ix];
      hi = book.last_seq[ix];
      case ($urandom_range(6))
        0: s = lo;
        1: s = hi;
        2: s = lo - 1;
        3: s = hi + 1;
        4: s = lo + seq_t'($urandom_range(3));
        5: s = SEQ_NONE;
        default: s = seq_cursor - seq_t'($urandom_range(40));
      endcase
    end
  endtask

  initial begin
    logic [FUNC_W-1:0] fn;
    seq_t              s;
    logic [IDX_W-1:0]  ix;
    int                setting;
    book = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // rotation off after reset: query always inside, rotates do nothing
    send_op(FN_QUERY, 64'd5, 4'd15);
    send_op(FN_ROT_WRITE, '0, '0);
    send_op(FN_ROT_READ, '0, '0);
    send_op(FN_COMMIT, 64'd0, '0);
    // unused selector values only report the state
    send_op(3'd5, SEQ_NONE, 4'd15);
    send_op(3'd6, 64'h5555_5555_5555_5555, 4'd5);
    send_op(3'd7, 64'hAAAA_AAAA_AAAA_AAAA, 4'd10);
    drain();

    // three files: fill, query inside a range and with the all-ones marker, index out of range, wrap onto the tail
    write_count(5'd3);
    send_op(FN_CLEAR, '0, '0);
    send_op(FN_COMMIT, 64'd10, '0);
    send_op(FN_COMMIT, 64'd20, '0);
    send_op(FN_QUERY, 64'd15, 4'd0);
    send_op(FN_QUERY, SEQ_NONE, 4'd0);
    send_op(FN_QUERY, 64'd15, 4'd3);
    send_op(FN_ROT_WRITE, '0, '0);
    send_op(FN_COMMIT, 64'd30, '0);
    send_op(FN_ROT_WRITE, '0, '0);
    send_op(FN_ROT_READ, '0, '0);
    send_op(FN_ROT_WRITE, '0, '0);
    send_op(FN_COMMIT, SEQ_NONE, '0);
    drain();

    // count above the slot total acts as the full ring
    write_count(5'd31);
    send_op(FN_ROT_WRITE, '0, '0);
    send_op(FN_ROT_WRITE, '0, '0);
    send_op(FN_ROT_WRITE, '0, '0);
    send_op(FN_QUERY, 64'd0, 4'd15);
    drain();

    // count lowered under the write head without a clear: head wraps on the next rotate
    write_count(5'd2);
    send_op(FN_ROT_WRITE, '0, '0);
    send_op(FN_QUERY, 64'h8000_0000_0000_0000, 4'd1);
    drain();

    // random phases, each on a fresh count setting, extremes first
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) setting = 16;
      else if (ph == 1) setting = 1;
      else if (ph == 2) setting = 0;
      else if (ph == 3) setting = 31;
      else if ($urandom_range(3) == 0) setting = 16;
      else setting = $urandom_range(2, 15);
      write_count(CNT_W'(setting));
      seq_cursor = {$urandom, $urandom} >> $urandom_range(63);
      // one phase runs its sequence numbers close below the all-ones marker
      if (ph == 5) seq_cursor = SEQ_NONE - 600;
      // receiver holds off for a long stretch while the sender keeps offering
      if (ph == 1 || ph == 7) hold_req++;
      for (int n = 0; n < PHASE_OPS; n++) begin
        set_idling((ph + n / 24) % 4);
        pick_op(fn, s, ix);
        send_op(fn, s, ix);
      end
      drain();
    end

    // let any stray result show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    book.flush_leftover();

    $display("ran %0d transfers over %0d count settings: %0d commits, %0d rotate writes,",
             items_sent, settings_used, book.op_seen[FN_COMMIT], book.op_seen[FN_ROT_WRITE]);
    $display("%0d rotate reads, %0d clears, %0d queries (%0d inside, %0d index errors),",
             book.op_seen[FN_ROT_READ], book.op_seen[FN_CLEAR], book.op_seen[FN_QUERY],
             book.hits, book.index_errors);
    $display("%0d failures", book.errors);
    if (book.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/rfsr_pkg.sv
hw/rtl/rfsr_mod.sv
hw/rtl/rfsr_dpath.sv
hw/rtl/rfsr_ctrl.sv
hw/rtl/rotating_file_sequence_ring.sv
hw/rtl/rfsr_checker.sv
tb/rotating_file_sequence_ring_tb.sv
